@@ src/dtq_pkg.sv @@
// Shared types and constants of the deadline timer queue.
`timescale 1ns / 1ps
`default_nettype none
package dtq_pkg;

  // Default sizes for the top level's parameters.
  localparam int DEPTH_DEF     = 16;
  localparam int TIME_BITS_DEF = 32;

  // At most this many due jobs leave on one tick.
  localparam int MAX_RESULTS = 16;
  localparam int RES_W       = $clog2(MAX_RESULTS + 1);

  // Fixed field widths of the words.
  localparam int INTERVAL_W = 20;
  localparam int JOB_W      = 8;
  localparam int KIND_W     = 2;
  localparam int IN_DATA_W  = 32;

  // Command codes on the input word.
  localparam logic CMD_TICK  = 1'b0;
  localparam logic CMD_SCHED = 1'b1;

  // Result kinds on the output word.
  localparam logic [KIND_W-1:0] KIND_SCHED  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_REJECT = 2'd1;
  localparam logic [KIND_W-1:0] KIND_DUE    = 2'd2;

  // Status of the age compare unit as seen by the sequencer.
  typedef struct packed {
    logic busy;
    logic found;
  } dtq_stat_t;

endpackage
`default_nettype wire

@@ src/dtq_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module dtq_ram #(
  parameter int WIDTH = 40,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule
`default_nettype wire

@@ src/dtq_age_unit.sv @@
// Shared age compare unit: finds the most overdue entry over a serial scan.
`timescale 1ns / 1ps
`default_nettype none
module dtq_age_unit #(
  parameter int TIME_BITS = 32,
  parameter int IDX_W     = 4
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   clear,
  input  wire logic                   in_valid,
  input  wire logic                   in_skip,
  input  wire logic [IDX_W-1:0]       in_idx,
  input  wire logic [TIME_BITS-1:0]   in_deadline,
  input  wire logic [dtq_pkg::JOB_W-1:0] in_job,
  input  wire logic [TIME_BITS-1:0]   now,
  output dtq_pkg::dtq_stat_t          stat,
  output logic [IDX_W-1:0]            best_idx,
  output logic [dtq_pkg::JOB_W-1:0]   best_job
);
  import dtq_pkg::*;

  // Stage one: wrap-safe age of the entry.
  logic                 v_r;
  logic                 due_r;
  logic [TIME_BITS-1:0] age_r;
  logic [IDX_W-1:0]     idx_r;
  logic [JOB_W-1:0]     job_r;

  // Stage two: best candidate so far.
  logic                 found_r;
  logic [TIME_BITS-1:0] best_age_r;
  logic [IDX_W-1:0]     best_idx_r;
  logic [JOB_W-1:0]     best_job_r;

  logic [TIME_BITS-1:0] age_nxt;
  logic                 take;

  assign age_nxt = now - in_deadline;
  // Strictly greater keeps the earliest inserted entry among equal deadlines.
  assign take = v_r && due_r && (!found_r || (age_r > best_age_r));

  always_ff @(posedge clk) begin
    if (!rst_n || clear) begin
      v_r     <= 1'b0;
      found_r <= 1'b0;
    end else begin
      v_r <= in_valid;
      if (take) begin
        found_r <= 1'b1;
      end
    end
    due_r <= !in_skip && !age_nxt[TIME_BITS-1];
    age_r <= age_nxt;
    idx_r <= in_idx;
    job_r <= in_job;
    if (take) begin
      best_age_r <= age_r;
      best_idx_r <= idx_r;
      best_job_r <= job_r;
    end
  end

  assign stat.busy  = v_r;
  assign stat.found = found_r;
  assign best_idx   = best_idx_r;
  assign best_job   = best_job_r;

endmodule
`default_nettype wire

@@ src/deadline_timer_queue_unit.sv @@
// Top level of the deadline timer queue: sequencer, entry store and output register.
`timescale 1ns / 1ps
`default_nettype none
// The block keeps a tick-driven millisecond counter of TIME_BITS bits and up
// to DEPTH pending one-shot jobs, each a deadline and an 8-bit job id, held in
// insertion order in one RAM. A schedule word (tuser 1) is answered with one
// result word in the cycle after it is taken: kind 0 when the job was stored
// with deadline now plus interval, kind 1 when the store was full. A tick word
// (tuser 0) advances the counter by one and then sends every job whose
// deadline has come, most overdue first, equal deadlines in insertion order,
// at most sixteen per tick, with tlast on the final one; a tick with nothing
// due sends nothing. "Has come" means the difference now minus deadline has
// its top bit clear, so the counter may wrap freely. A schedule word is done
// in the cycle in which it is taken, and so is a tick with an empty store.
// With jobs pending, a tick walks the RAM through one read port and the
// shared age compare unit; it makes one walk per due job plus a final one
// that finds nothing (skipped when the store empties or sixteen were found),
// hands out the final job, then packs the survivors down in order. The
// input is not ready while a tick is at work or while an undelivered result
// word blocks the output register, and a stalled receiver lengthens a tick.
module deadline_timer_queue_unit #(
  parameter int DEPTH     = dtq_pkg::DEPTH_DEF,
  parameter int TIME_BITS = dtq_pkg::TIME_BITS_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_tvalid,
  output logic                            in_tready,
  // in_tdata: [19:0] interval, [27:20] job_id, [31:28] zero
  input  wire logic [dtq_pkg::IN_DATA_W-1:0] in_tdata,
  // in_tuser: [0] cmd
  input  wire logic                       in_tuser,
  output logic                            out_tvalid,
  input  wire logic                       out_tready,
  // out_tdata: [7:0] due_job
  output logic [dtq_pkg::JOB_W-1:0]       out_tdata,
  // out_tuser: [1:0] kind
  output logic [dtq_pkg::KIND_W-1:0]      out_tuser,
  output logic                            out_tlast
);
  import dtq_pkg::*;

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int ENT_W = TIME_BITS + JOB_W;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_WAIT,
    ST_DECIDE,
    ST_FINISH,
    ST_COMPACT,
    ST_CDRAIN
  } state_t;

  state_t               state_r;
  logic [TIME_BITS-1:0] now_r;
  logic [CNT_W-1:0]     cnt_r;
  logic [CNT_W-1:0]     rem_r;
  logic [RES_W-1:0]     sel_r;
  logic [IDX_W-1:0]     rd_idx_r;
  logic [IDX_W-1:0]     tag_r;
  logic                 rd_v1_r;
  logic [IDX_W-1:0]     wi_r;
  logic [DEPTH-1:0]     removed_r;
  logic                 pend_v_r;
  logic [JOB_W-1:0]     pend_job_r;

  logic                 out_tvalid_r;
  logic [JOB_W-1:0]     out_job_r;
  logic [KIND_W-1:0]    out_kind_r;
  logic                 out_last_r;

  // Unpacked input word.
  logic [INTERVAL_W-1:0] in_interval;
  logic [JOB_W-1:0]      in_job;
  assign in_interval = in_tdata[INTERVAL_W-1:0];
  assign in_job      = in_tdata[INTERVAL_W +: JOB_W];

  logic out_free;
  logic out_load;
  logic in_acc;
  logic full;
  logic last_rd;
  logic sched_wr;
  logic cmp_wr;
  logic unit_clear;
  logic unit_valid;
  logic dec_ok;

  logic                 ram_we;
  logic [IDX_W-1:0]     ram_waddr;
  logic [ENT_W-1:0]     ram_wdata;
  logic [ENT_W-1:0]     ram_rdata;

  dtq_stat_t            ustat;
  logic [IDX_W-1:0]     best_idx;
  logic [JOB_W-1:0]     best_job;

  assign out_free  = !out_tvalid_r || out_tready;
  assign in_tready = (state_r == ST_IDLE) && out_free;
  assign in_acc    = in_tvalid && in_tready;
  assign full      = (cnt_r == CNT_W'(DEPTH));
  assign last_rd   = (CNT_W'(rd_idx_r) == (cnt_r - CNT_W'(1)));
  assign dec_ok    = !pend_v_r || out_free;

  // A new result word enters the output register on a schedule answer, on a
  // due job that turns out not to be the last, and on the final due job.
  assign out_load = (in_acc && (in_tuser == CMD_SCHED))
                    || ((state_r == ST_DECIDE) && ustat.found && dec_ok && pend_v_r)
                    || ((state_r == ST_FINISH) && out_free);

  // Schedule appends at the end; packing writes survivors down in order.
  assign sched_wr   = in_acc && (in_tuser == CMD_SCHED) && !full;
  assign cmp_wr     = rd_v1_r && ((state_r == ST_COMPACT) || (state_r == ST_CDRAIN))
                      && !removed_r[tag_r];
  assign unit_valid = rd_v1_r && ((state_r == ST_SCAN) || (state_r == ST_WAIT));
  // Keep the unit's best entry until the decision has really been taken.
  assign unit_clear = (state_r == ST_IDLE)
                      || ((state_r == ST_DECIDE) && ustat.found && dec_ok);

  always_comb begin
    ram_we    = sched_wr || cmp_wr;
    ram_waddr = cmp_wr ? wi_r : cnt_r[IDX_W-1:0];
    ram_wdata = cmp_wr ? ram_rdata
                       : {now_r + TIME_BITS'(in_interval), in_job};
  end

  dtq_ram #(
    .WIDTH (ENT_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (rd_idx_r),
    .rdata (ram_rdata)
  );

  dtq_age_unit #(
    .TIME_BITS (TIME_BITS),
    .IDX_W     (IDX_W)
  ) u_age (
    .clk         (clk),
    .rst_n       (rst_n),
    .clear       (unit_clear),
    .in_valid    (unit_valid),
    .in_skip     (removed_r[tag_r]),
    .in_idx      (tag_r),
    .in_deadline (ram_rdata[JOB_W +: TIME_BITS]),
    .in_job      (ram_rdata[JOB_W-1:0]),
    .now         (now_r),
    .stat        (ustat),
    .best_idx    (best_idx),
    .best_job    (best_job)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      now_r        <= '0;
      cnt_r        <= '0;
      rem_r        <= '0;
      sel_r        <= '0;
      rd_v1_r      <= 1'b0;
      wi_r         <= '0;
      removed_r    <= '0;
      pend_v_r     <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      rd_v1_r <= (state_r == ST_SCAN) || (state_r == ST_COMPACT);
      tag_r   <= rd_idx_r;
      if (out_load) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tvalid_r && out_tready) begin
        out_tvalid_r <= 1'b0;
      end
      if (cmp_wr) begin
        wi_r <= wi_r + IDX_W'(1);
      end

      unique case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            if (in_tuser == CMD_SCHED) begin
              out_kind_r   <= full ? KIND_REJECT : KIND_SCHED;
              out_job_r    <= in_job;
              out_last_r   <= 1'b1;
              if (!full) begin
                cnt_r <= cnt_r + CNT_W'(1);
              end
            end else begin
              now_r <= now_r + TIME_BITS'(1);
              if (cnt_r != '0) begin
                state_r  <= ST_SCAN;
                rd_idx_r <= '0;
                sel_r    <= '0;
                rem_r    <= '0;
              end
            end
          end
        end
        ST_SCAN: begin
          rd_idx_r <= rd_idx_r + IDX_W'(1);
          if (last_rd) begin
            state_r <= ST_WAIT;
          end
        end
        ST_WAIT: begin
          if (!rd_v1_r && !ustat.busy) begin
            state_r <= ST_DECIDE;
          end
        end
        ST_DECIDE: begin
          if (ustat.found) begin
            if (dec_ok) begin
              // The previous find is not the last one, so it goes out now.
              if (pend_v_r) begin
                out_kind_r   <= KIND_DUE;
                out_job_r    <= pend_job_r;
                out_last_r   <= 1'b0;
              end
              pend_v_r            <= 1'b1;
              pend_job_r          <= best_job;
              removed_r[best_idx] <= 1'b1;
              sel_r               <= sel_r + RES_W'(1);
              rem_r               <= rem_r + CNT_W'(1);
              if ((sel_r == RES_W'(MAX_RESULTS - 1))
                  || (rem_r == (cnt_r - CNT_W'(1)))) begin
                state_r <= ST_FINISH;
              end else begin
                state_r  <= ST_SCAN;
                rd_idx_r <= '0;
              end
            end
          end else if (pend_v_r) begin
            state_r <= ST_FINISH;
          end else begin
            state_r <= ST_IDLE;
          end
        end
        ST_FINISH: begin
          if (out_free) begin
            out_kind_r   <= KIND_DUE;
            out_job_r    <= pend_job_r;
            out_last_r   <= 1'b1;
            pend_v_r     <= 1'b0;
            state_r      <= ST_COMPACT;
            rd_idx_r     <= '0;
            wi_r         <= '0;
          end
        end
        ST_COMPACT: begin
          rd_idx_r <= rd_idx_r + IDX_W'(1);
          if (last_rd) begin
            state_r <= ST_CDRAIN;
          end
        end
        ST_CDRAIN: begin
          if (!rd_v1_r) begin
            cnt_r     <= cnt_r - rem_r;
            rem_r     <= '0;
            removed_r <= '0;
            state_r   <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_job_r;
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;

endmodule
`default_nettype wire

@@ src/dtq_checker.sv @@
// Port-level checks of the deadline timer queue, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module dtq_checker (
  input wire logic                         clk,
  input wire logic                         rst_n,
  input wire logic                         in_tvalid,
  input wire logic                         in_tready,
  input wire logic                         in_tuser,
  input wire logic                         out_tvalid,
  input wire logic                         out_tready,
  input wire logic [dtq_pkg::JOB_W-1:0]    out_tdata,
  input wire logic [dtq_pkg::KIND_W-1:0]   out_tuser,
  input wire logic                         out_tlast
);
  import dtq_pkg::*;

  // A stalled result word stays put.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata)
                                  && $stable(out_tuser) && $stable(out_tlast))
    else $error("result word changed while stalled");

  // A schedule word is answered in the next cycle with one final word.
  a_sched_answer: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tuser == CMD_SCHED)
      |=> out_tvalid && out_tlast
          && ((out_tuser == KIND_SCHED) || (out_tuser == KIND_REJECT)))
    else $error("schedule word not answered");

  // Due jobs of a tick appear only after the scan, never in the next cycle.
  a_tick_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tuser == CMD_TICK) |=> !out_tvalid)
    else $error("result word right after a tick");

  // Schedule answers are single words.
  a_ack_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser != KIND_DUE) |-> out_tlast)
    else $error("schedule answer without tlast");

endmodule

bind deadline_timer_queue_unit dtq_checker u_dtq_checker (.*);
`default_nettype wire
